// File: rtl/hbe_pkg.sv
// Shared constants, types and helpers for the histogram binning engine.
`timescale 1ns / 1ps

package hbe_pkg;

	localparam int MAX_BINS     = 64;
	localparam int SAMPLE_WIDTH = 24;
	localparam int COUNT_WIDTH  = 32;

	localparam int BCNT_W      = 6;
	localparam int IDX_W       = $clog2(MAX_BINS);
	localparam int TOTAL_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int DIVIDEND_W  = SAMPLE_WIDTH + BCNT_W + 2;
	localparam int DIVISOR_W   = SAMPLE_WIDTH + 1;
	localparam int OUT_FIELD_W = BCNT_W + 2 * TOTAL_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

	localparam logic [SAMPLE_WIDTH-1:0] RANGE_MIN_RST = '0;
	localparam logic [SAMPLE_WIDTH-1:0] RANGE_MAX_RST = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [BCNT_W-1:0]       BIN_COUNT_RST = 6'd63;
	localparam logic [BCNT_W-1:0]       TOP_LIMIT     = BCNT_W'(MAX_BINS - 1);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_UPDATE,
		ST_RD_REQ,
		ST_RD_DATA,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_ctl_t;

	typedef struct packed {
		logic              done;
		logic [BCNT_W-1:0] quot;
	} div_stat_t;

	function automatic count_t sat_inc(input count_t c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

endpackage

// File: rtl/hbe_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hbe_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  hbe_pkg::div_ctl_t  ctl,
	output hbe_pkg::div_stat_t stat
);

	localparam int QUOT_W = hbe_pkg::BCNT_W;
	localparam int STEP_W = $clog2(QUOT_W);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [hbe_pkg::DIVIDEND_W-1:0] rem_q;
	logic [hbe_pkg::DIVIDEND_W-1:0] dvs_q;
	logic [QUOT_W-1:0]             quot_q;
	logic                          ge;

	assign ge = (rem_q >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUOT_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= ctl.dividend;
			dvs_q  <= hbe_pkg::DIVIDEND_W'(ctl.divisor) << (QUOT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			dvs_q  <= dvs_q >> 1;
		end
	end

	assign stat = {done_q, quot_q};

endmodule

// File: rtl/histogram_binning_engine.sv
// Top level of the histogram binning engine: sequencer, bin counter memory and readout.
//
//  channel  | dir | signals                              | transaction
//  ---------+-----+--------------------------------------+---------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata s_tlast    | one sample, tlast = batch end
//  m_       | out | m_tvalid m_tready m_tdata m_tlast    | one bin report, tlast = final bin
//  cfg_     | in  | cfg_we cfg_idx cfg_data              | register write, no wait
//
//  A sample passes through accept, range check, multiply, divider load, six
//  shift-subtract steps plus result, and counter update.
//  A dropped sample passes through accept and range check only.
//  Readout of each bin passes through memory read, output load and transaction, plus any stalls on m_tready.
//  After reset the counters read as zero through per-bin valid flags; no clearing pass.
//  Input is not ready while a sample or a readout is in progress.
`timescale 1ns / 1ps

module histogram_binning_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hbe_pkg::IN_TDATA_W-1:0]      s_tdata,  // sample
	input  logic                                s_tlast,  // batch_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hbe_pkg::OUT_TDATA_W-1:0]     m_tdata,  // bin_index, bin_total, dropped_total
	output logic                                m_tlast,  // final_bin
	input  logic                                cfg_we,
	input  logic [hbe_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [hbe_pkg::SAMPLE_WIDTH-1:0]    cfg_data
);

	localparam int SW = hbe_pkg::SAMPLE_WIDTH;
	localparam int BW = hbe_pkg::BCNT_W;
	localparam int IW = hbe_pkg::IDX_W;

	hbe_pkg::state_t state_q, state_d;

	logic signed [SW-1:0] range_min_q, range_max_q;
	logic [BW-1:0]        bin_count_q;
	logic [BW-1:0]        top;

	logic signed [SW-1:0] sample_q;
	logic                 last_q;
	logic [SW-1:0]        diff_q, den_q;
	logic [SW+BW-1:0]     num_q;
	logic [BW-1:0]        upd_idx_q, rd_idx_q;
	logic [BW-1:0]        quot_clamped;

	hbe_pkg::count_t      cnt_mem [hbe_pkg::MAX_BINS];
	hbe_pkg::count_t      rdata_q;
	logic [hbe_pkg::MAX_BINS-1:0] valid_q;
	hbe_pkg::count_t      dropped_q;

	logic [IW-1:0]        mem_raddr;
	logic                 mem_we;
	hbe_pkg::count_t      cur_cnt, rd_cnt;

	logic                 m_tvalid_q, m_tlast_q;
	logic [hbe_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic                 drop, drop_inc, clear_all, out_load, out_done, rd_inc, upd_load;
	logic signed [SW:0]   diff_full, den_full;

	hbe_pkg::div_ctl_t    div_ctl;
	hbe_pkg::div_stat_t   div_stat;

	hbe_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.stat   (div_stat)
	);

	assign top = (bin_count_q > hbe_pkg::TOP_LIMIT) ? hbe_pkg::TOP_LIMIT : bin_count_q;

	assign diff_full = {sample_q[SW-1], sample_q} - {range_min_q[SW-1], range_min_q};
	assign den_full  = {range_max_q[SW-1], range_max_q} - {range_min_q[SW-1], range_min_q};
	assign drop      = (range_max_q <= range_min_q) || (sample_q < range_min_q)
	                   || (sample_q > range_max_q);

	assign quot_clamped = (div_stat.quot > top) ? top : div_stat.quot;

	assign cur_cnt = valid_q[upd_idx_q[IW-1:0]] ? rdata_q : '0;
	assign rd_cnt  = valid_q[rd_idx_q[IW-1:0]] ? rdata_q : '0;

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		div_ctl.start    = 1'b0;
		div_ctl.dividend = hbe_pkg::DIVIDEND_W'({num_q, 1'b0})
		                   + hbe_pkg::DIVIDEND_W'(den_q);
		div_ctl.divisor  = {den_q, 1'b0};
		mem_raddr        = '0;
		mem_we           = 1'b0;
		drop_inc         = 1'b0;
		clear_all        = 1'b0;
		out_load         = 1'b0;
		out_done         = 1'b0;
		rd_inc           = 1'b0;
		upd_load         = 1'b0;
		case (state_q)
			hbe_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = hbe_pkg::ST_CHECK;
				end
			end
			hbe_pkg::ST_CHECK: begin
				if (drop) begin
					drop_inc = 1'b1;
					state_d  = last_q ? hbe_pkg::ST_RD_REQ : hbe_pkg::ST_IDLE;
				end else begin
					state_d = hbe_pkg::ST_MUL;
				end
			end
			hbe_pkg::ST_MUL: begin
				state_d = hbe_pkg::ST_START;
			end
			hbe_pkg::ST_START: begin
				div_ctl.start = 1'b1;
				state_d       = hbe_pkg::ST_DIV;
			end
			hbe_pkg::ST_DIV: begin
				if (div_stat.done) begin
					mem_raddr = quot_clamped[IW-1:0];
					upd_load  = 1'b1;
					state_d   = hbe_pkg::ST_UPDATE;
				end
			end
			hbe_pkg::ST_UPDATE: begin
				mem_we  = 1'b1;
				state_d = last_q ? hbe_pkg::ST_RD_REQ : hbe_pkg::ST_IDLE;
			end
			hbe_pkg::ST_RD_REQ: begin
				mem_raddr = rd_idx_q[IW-1:0];
				state_d   = hbe_pkg::ST_RD_DATA;
			end
			hbe_pkg::ST_RD_DATA: begin
				out_load = 1'b1;
				state_d  = hbe_pkg::ST_RD_OUT;
			end
			hbe_pkg::ST_RD_OUT: begin
				if (m_tready) begin
					out_done = 1'b1;
					if (rd_idx_q == top) begin
						clear_all = 1'b1;
						state_d   = hbe_pkg::ST_IDLE;
					end else begin
						rd_inc  = 1'b1;
						state_d = hbe_pkg::ST_RD_REQ;
					end
				end
			end
			default: begin
				state_d = hbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hbe_pkg::ST_IDLE;
			range_min_q <= hbe_pkg::RANGE_MIN_RST;
			range_max_q <= hbe_pkg::RANGE_MAX_RST;
			bin_count_q <= hbe_pkg::BIN_COUNT_RST;
			valid_q     <= '0;
			dropped_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					hbe_pkg::CFG_RANGE_MIN: range_min_q <= cfg_data;
					hbe_pkg::CFG_RANGE_MAX: range_max_q <= cfg_data;
					hbe_pkg::CFG_BIN_COUNT: bin_count_q <= cfg_data[BW-1:0];
					default: ;
				endcase
			end
			if (clear_all) begin
				valid_q   <= '0;
				dropped_q <= '0;
			end else begin
				if (mem_we) begin
					valid_q[upd_idx_q[IW-1:0]] <= 1'b1;
				end
				if (drop_inc) begin
					dropped_q <= hbe_pkg::sat_inc(dropped_q);
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (out_done) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_q <= s_tdata[SW-1:0];
			last_q   <= s_tlast;
			rd_idx_q <= '0;
		end else if (rd_inc) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (state_q == hbe_pkg::ST_CHECK) begin
			diff_q <= diff_full[SW-1:0];
			den_q  <= den_full[SW-1:0];
		end
		if (state_q == hbe_pkg::ST_MUL) begin
			num_q <= diff_q * top;
		end
		if (upd_load) begin
			upd_idx_q <= quot_clamped;
		end
		if (out_load) begin
			m_tdata_q <= hbe_pkg::OUT_TDATA_W'({32'(dropped_q), 32'(rd_cnt), rd_idx_q});
			m_tlast_q <= (rd_idx_q == top);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem[upd_idx_q[IW-1:0]] <= hbe_pkg::sat_inc(cur_cnt);
		end
		rdata_q <= cnt_mem[mem_raddr];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
